@@ sv/ra_mutex_pkg.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_pkg
// Shared widths, op and message codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ra_mutex_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int SPAN_CAP      = 16;

	localparam int OP_W   = 3;
	localparam int SEQ_W  = 32;
	localparam int NODE_W = 4;
	localparam int KIND_W = 3;
	localparam int CNT_W  = 5;
	localparam int REPL_W = 6;
	localparam int CFG_W  = 5;
	localparam int ADDR_W = 1;
	localparam int DATA_W = 40;

	localparam logic [OP_W-1:0] OP_CLI_REQ    = 3'd0;
	localparam logic [OP_W-1:0] OP_CLI_REL    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLI_DONE   = 3'd2;
	localparam logic [OP_W-1:0] OP_PEER_REQ   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEER_REPLY = 3'd4;
	localparam logic [OP_W-1:0] OP_PEER_DONE  = 3'd5;

	localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd4;

	localparam logic [ADDR_W-1:0] REG_NODE_ID    = 1'b0;
	localparam logic [ADDR_W-1:0] REG_NODE_COUNT = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
		logic walk;
		logic grant;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic finished;
		logic op_valid;
		logic op_walk;
		logic walk_end;
		logic cand;
		logic grant_due;
		logic pend_valid;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ sv/ricart_agrawala_mutex_node.sv @@
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node
// One node of Ricart-Agrawala distributed mutual exclusion.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one event per transaction; s_tuser carries the op
//   (client request/release/done, peer request/reply/done), s_tdata the
//   peer sequence number and peer index.
//   Output stream m_*: one message per transaction; m_tuser is the kind
//   (request, reply, done notice, grant), m_tdata the destination and
//   sequence number, m_tlast marks the final message of an event.
//   Config port: cfg_we/cfg_addr/cfg_data write node_id (0) and
//   node_count (1); write only while no event is in flight.
// Timing:
//   Client events walk the node bits one per cycle unless a stalled output
//   holds the walk, span = min(node_count, MAX_NODES, 16); peer events go
//   through start, check and flush, and ignored events end at start. Each
//   message passes the pending register, then the output register.
// Reset clears all node state: not requesting, countdown idle, every node
// alive, nothing postponed. A stalled receiver holds the output register
// and halts the walk at a node that is due a message until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ricart_agrawala_mutex_node #(
	parameter int MAX_NODES = ra_mutex_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ra_mutex_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire logic [ra_mutex_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [ra_mutex_pkg::DATA_W-1:0]   s_tdata,  // peer_seq, peer_node
	input  wire logic [ra_mutex_pkg::OP_W-1:0]     s_tuser,  // op
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [ra_mutex_pkg::DATA_W-1:0]        m_tdata,  // dest_node, seq_out
	output logic [ra_mutex_pkg::KIND_W-1:0]        m_tuser,  // msg_kind
	output logic                                   m_tlast
);

	ra_mutex_pkg::dp_cmd_t cmd;
	ra_mutex_pkg::dp_sts_t sts;

	ra_mutex_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ra_mutex_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire

@@ sv/ra_mutex_dp.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_dp
// Datapath: node state, node walk, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ra_mutex_dp #(
	parameter int MAX_NODES = ra_mutex_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ra_mutex_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire logic [ra_mutex_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [ra_mutex_pkg::DATA_W-1:0]   s_tdata,
	input  wire logic [ra_mutex_pkg::OP_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [ra_mutex_pkg::DATA_W-1:0]        m_tdata,
	output logic [ra_mutex_pkg::KIND_W-1:0]        m_tuser,
	output logic                                   m_tlast,
	input  wire ra_mutex_pkg::dp_cmd_t             cmd,
	output ra_mutex_pkg::dp_sts_t                  sts
);

	localparam int SW = ra_mutex_pkg::SEQ_W;
	localparam int NW = ra_mutex_pkg::NODE_W;
	localparam int KW = ra_mutex_pkg::KIND_W;
	localparam int CW = ra_mutex_pkg::CNT_W;
	localparam int RW = ra_mutex_pkg::REPL_W;
	localparam int SC = ra_mutex_pkg::SPAN_CAP;
	localparam int SPAN_LIM_I = (MAX_NODES < SC) ? MAX_NODES : SC;
	localparam logic [CW-1:0] SPAN_LIM = CW'(SPAN_LIM_I);
	localparam int PAD_W = ra_mutex_pkg::DATA_W - SW - NW;

	logic [NW-1:0]          node_id_q;
	logic [CW-1:0]          node_count_q;
	logic [SW-1:0]          highest_q;
	logic [SW-1:0]          own_seq_q;
	logic                   requesting_q;
	logic signed [RW-1:0]   replies_q;
	logic [MAX_NODES-1:0]   alive_q;
	logic [MAX_NODES-1:0]   post_q;
	logic                   finished_q;
	logic [CW-1:0]          walk_q;

	logic [ra_mutex_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]          seq_q;
	logic [NW-1:0]          node_q;

	logic                   pend_valid_q;
	logic [KW-1:0]          pend_kind_q;
	logic [NW-1:0]          pend_dest_q;
	logic [SW-1:0]          pend_seq_q;

	logic                   m_valid_q;
	logic [KW-1:0]          m_kind_q;
	logic [NW-1:0]          m_dest_q;
	logic [SW-1:0]          m_seq_q;
	logic                   m_last_q;

	logic [SC-1:0]          alive_win;
	logic [SC-1:0]          post_win;
	logic [CW-1:0]          span;
	logic [NW-1:0]          cur_idx;
	logic                   is_self;
	logic                   cand;
	logic                   defer;
	logic                   out_free;
	logic                   emit;
	logic                   push;
	logic [KW-1:0]          emit_kind;
	logic [NW-1:0]          emit_dest;
	logic [SW-1:0]          emit_seq;
	logic [SW-1:0]          next_seq;

	for (genvar k = 0; k < SC; k++) begin : g_win
		if (k < MAX_NODES) begin : g_on
			assign alive_win[k] = alive_q[k];
			assign post_win[k]  = post_q[k];
		end else begin : g_off
			assign alive_win[k] = 1'b0;
			assign post_win[k]  = 1'b0;
		end
	end

	assign span     = (node_count_q > SPAN_LIM) ? SPAN_LIM : node_count_q;
	assign cur_idx  = walk_q[NW-1:0];
	assign is_self  = (cur_idx == node_id_q);
	assign out_free = !m_valid_q || m_tready;
	assign next_seq = (highest_q == {SW{1'b1}}) ? highest_q : highest_q + SW'(1);

	always_comb begin
		cand = 1'b0;
		case (op_q) inside
			ra_mutex_pkg::OP_CLI_REQ,
			ra_mutex_pkg::OP_CLI_DONE: cand = alive_win[cur_idx] && !is_self;
			ra_mutex_pkg::OP_CLI_REL:  cand = alive_win[cur_idx] && !is_self && post_win[cur_idx];
			default:                   cand = 1'b0;
		endcase
	end

	assign defer = requesting_q &&
		((seq_q > own_seq_q) || ((seq_q == own_seq_q) && (node_q > node_id_q)));

	always_comb begin
		emit_kind = ra_mutex_pkg::KIND_REPLY;
		emit_dest = node_q;
		emit_seq  = '0;
		if (cmd.grant) begin
			emit_kind = ra_mutex_pkg::KIND_GRANT;
			emit_dest = node_id_q;
		end else if (cmd.walk) begin
			emit_dest = cur_idx;
			case (op_q)
				ra_mutex_pkg::OP_CLI_REQ: begin
					emit_kind = ra_mutex_pkg::KIND_REQUEST;
					emit_seq  = own_seq_q;
				end
				ra_mutex_pkg::OP_CLI_DONE: emit_kind = ra_mutex_pkg::KIND_DONE;
				default:                   emit_kind = ra_mutex_pkg::KIND_REPLY;
			endcase
		end
	end

	assign emit = cmd.grant || (cmd.walk && cand) ||
		(cmd.start && (op_q == ra_mutex_pkg::OP_PEER_REQ) && !defer);
	assign push = (emit && pend_valid_q) || (cmd.flush && pend_valid_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q    <= '0;
			node_count_q <= CW'(16);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ra_mutex_pkg::REG_NODE_ID:    node_id_q    <= cfg_data[NW-1:0];
				ra_mutex_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tuser;
			seq_q  <= s_tdata[SW-1:0];
			node_q <= s_tdata[SW+NW-1:SW];
		end
	end

	// node state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q    <= '0;
			own_seq_q    <= '0;
			requesting_q <= 1'b0;
			replies_q    <= '1;
			finished_q   <= 1'b0;
			walk_q       <= '0;
			alive_q      <= '1;
			post_q       <= '0;
		end else begin
			if (cmd.start) begin
				walk_q <= '0;
				case (op_q)
					ra_mutex_pkg::OP_CLI_REQ: begin
						requesting_q <= 1'b1;
						own_seq_q    <= next_seq;
						replies_q    <= '0;
					end
					ra_mutex_pkg::OP_CLI_REL:  requesting_q <= 1'b0;
					ra_mutex_pkg::OP_CLI_DONE: finished_q   <= 1'b1;
					ra_mutex_pkg::OP_PEER_REQ: begin
						if (seq_q > highest_q)
							highest_q <= seq_q;
					end
					ra_mutex_pkg::OP_PEER_REPLY: begin
						if (replies_q > RW'(0))
							replies_q <= replies_q - RW'(1);
					end
					default: ;
				endcase
			end
			if (cmd.walk) begin
				walk_q <= walk_q + CW'(1);
				if (cand && (op_q == ra_mutex_pkg::OP_CLI_REQ))
					replies_q <= replies_q + RW'(1);
			end
			if (cmd.grant)
				replies_q <= '1;
			for (int k = 0; k < MAX_NODES; k++) begin
				if (cmd.start && (op_q == ra_mutex_pkg::OP_PEER_DONE) && (int'(node_q) == k))
					alive_q[k] <= 1'b0;
				if (cmd.start && (op_q == ra_mutex_pkg::OP_PEER_REQ) && defer &&
						(int'(node_q) == k))
					post_q[k] <= 1'b1;
				if (cmd.walk && cand && (op_q == ra_mutex_pkg::OP_CLI_REL) &&
						(int'(cur_idx) == k))
					post_q[k] <= 1'b0;
			end
		end
	end

	// pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (emit)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (push)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_kind_q <= emit_kind;
			pend_dest_q <= emit_dest;
			pend_seq_q  <= emit_seq;
		end
		if (push) begin
			m_kind_q <= pend_kind_q;
			m_dest_q <= pend_dest_q;
			m_seq_q  <= pend_seq_q;
			m_last_q <= cmd.flush;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_seq_q, m_dest_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	assign sts.finished   = finished_q;
	assign sts.op_valid   = (op_q <= ra_mutex_pkg::OP_PEER_DONE);
	assign sts.op_walk    = (op_q <= ra_mutex_pkg::OP_CLI_DONE);
	assign sts.walk_end   = (walk_q == span);
	assign sts.cand       = cand;
	assign sts.grant_due  = (replies_q == RW'(0));
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	a_replies_range: assert property (@(posedge clk) disable iff (!arst_n)
		!(replies_q[RW-1] && (replies_q != '1)))
		else $error("reply countdown below idle");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_valid_q)
		else $error("new transaction with a result still pending");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (walk_q < span))
		else $error("walk beyond node span");

	a_grant_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |=> (replies_q == '1))
		else $error("countdown not idle after grant");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output overwritten");

endmodule

`default_nettype wire

@@ sv/ra_mutex_ctrl.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_ctrl
// Controller: sequences one event through start, node walk, grant and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ra_mutex_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	output ra_mutex_pkg::dp_cmd_t       cmd,
	input  wire ra_mutex_pkg::dp_sts_t  sts
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_WALK  = 5'b00100,
		S_CHECK = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   can_emit;

	assign can_emit = !sts.pend_valid || sts.out_free;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (!sts.op_valid || sts.finished) begin
					state_d = S_IDLE;
				end else begin
					cmd.start = 1'b1;
					state_d   = sts.op_walk ? S_WALK : S_CHECK;
				end
			end
			S_WALK: begin
				if (sts.walk_end)
					state_d = S_CHECK;
				else if (!sts.cand || can_emit)
					cmd.walk = 1'b1;
			end
			S_CHECK: begin
				if (!sts.grant_due) begin
					state_d = S_FLUSH;
				end else if (can_emit) begin
					cmd.grant = 1'b1;
					state_d   = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start, cmd.walk, cmd.grant, cmd.flush}))
		else $error("more than one datapath command");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_START))
		else $error("accepted transaction not started");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> s_tready)
		else $error("not ready after final result");

endmodule

`default_nettype wire
